[sv/pcp_pkg.sv]
package pcp_pkg;

	// Parser phases, one-hot
	typedef enum logic [5:0] {
		PH_SIG  = 6'b000001,
		PH_LEN  = 6'b000010,
		PH_TYPE = 6'b000100,
		PH_DATA = 6'b001000,
		PH_CRC  = 6'b010000,
		PH_HALT = 6'b100000
	} phase_t;

	// Result codes
	typedef enum logic [2:0] {
		EV_IHDR      = 3'd0,
		EV_SRGB      = 3'd1,
		EV_GAMA      = 3'd2,
		EV_PHYS      = 3'd3,
		EV_TIME      = 3'd4,
		EV_TEXT      = 3'd5,
		EV_BAD_SIG   = 3'd6,
		EV_BAD_FIRST = 3'd7
	} event_kind_t;

	// Chunk type codes, big-endian ASCII
	localparam logic [31:0] T_IHDR = 32'h4948_4452;
	localparam logic [31:0] T_SRGB = 32'h7352_4742;
	localparam logic [31:0] T_GAMA = 32'h6741_4D41;
	localparam logic [31:0] T_PHYS = 32'h7048_5973;
	localparam logic [31:0] T_TIME = 32'h7449_4D45;
	localparam logic [31:0] T_TEXT = 32'h7445_5874;

	// Number of data bytes captured: eight in the field word, five in the detail word
	localparam logic [31:0] FIELD_BYTES = 32'd8;
	localparam logic [31:0] DATA_BYTES  = 32'd13;

	// File signature byte at a given position
	function automatic logic [7:0] sig_byte(input logic [2:0] idx);
		logic [7:0] val;
		case (idx)
			3'd0:    val = 8'd137;
			3'd1:    val = 8'd80;
			3'd2:    val = 8'd78;
			3'd3:    val = 8'd71;
			3'd4:    val = 8'd13;
			3'd5:    val = 8'd10;
			3'd6:    val = 8'd26;
			3'd7:    val = 8'd10;
			default: val = 8'd10;
		endcase
		return val;
	endfunction

endpackage

[sv/png_metadata_chunk_parser.sv]
// PNG metadata parser, one file byte per transfer. It checks the eight-byte signature, requires
// IHDR as the first chunk and then walks the chunks, skipping every CRC unchecked. At the end of
// the first IHDR chunk, or of an sRGB, gAMA, pHYs or tIME chunk, it gives one result with the
// decoded fields; every tEXt data byte gives a result as it arrives; all other chunks are skipped.
// A bad signature or a bad first chunk gives an error result and the block then takes bytes but
// ignores them until reset. Throughput is one byte per clock while the result register is not
// stalled: each byte passes an input register and one shallow decode step (a 32-bit position
// increment and compare against the chunk length) into the result register. Only a stalled
// result register holds up the input side.
module png_metadata_chunk_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic [7:0]  stream_byte,
	output logic        event_valid,
	input  logic        event_stall,
	output logic [2:0]  event_kind,
	output logic [31:0] word_one,
	output logic [31:0] word_two,
	output logic [39:0] packed_detail,
	output logic [7:0]  small_value
);
	import pcp_pkg::*;

	// Input stage
	logic        byte_valid_s1;
	logic [7:0]  byte_s1;

	// Parser state
	phase_t      phase_q, phase_d;
	logic [31:0] pos_q, pos_d, pos_inc;
	logic [31:0] len_q, len_d;
	logic [31:0] type_q, type_d;
	logic        first_q, first_d;
	logic [63:0] fa_q, fa_d;
	logic [39:0] da_q, da_d;

	// Result register
	logic        ev_valid_q;
	event_kind_t kind_q;
	logic [31:0] w1_q, w2_q;
	logic [39:0] det_q;
	logic [7:0]  sv_q;

	// Decode outputs
	logic        res_valid;
	event_kind_t res_kind;
	logic [31:0] res_w1, res_w2;
	logic [39:0] res_det;
	logic [7:0]  res_sv;
	logic        finish;
	logic [2:0]  det_sel;

	logic adv, fire, load_in;

	// Flow control: the decode step moves when the result register is free or draining
	assign adv        = !ev_valid_q || !event_stall;
	assign fire       = byte_valid_s1 && adv;
	assign load_in    = !byte_valid_s1 || adv;
	assign byte_stall = !load_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid_s1 <= 1'b0;
		end else if (load_in) begin
			byte_valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_in && byte_valid) begin
			byte_s1 <= stream_byte;
		end
	end

	// Decode one byte against the current phase
	always_comb begin
		phase_d   = phase_q;
		pos_d     = pos_q;
		len_d     = len_q;
		type_d    = type_q;
		first_d   = first_q;
		fa_d      = fa_q;
		da_d      = da_q;
		res_valid = 1'b0;
		res_kind  = EV_IHDR;
		res_w1    = '0;
		res_w2    = '0;
		res_det   = '0;
		res_sv    = '0;
		finish    = 1'b0;
		pos_inc   = pos_q + 32'd1;
		det_sel   = 3'd4 - pos_q[2:0];

		case (phase_q)
			PH_SIG: begin
				if (byte_s1 != sig_byte(pos_q[2:0])) begin
					phase_d   = PH_HALT;
					res_valid = 1'b1;
					res_kind  = EV_BAD_SIG;
				end else if (pos_q[2:0] == 3'd7) begin
					phase_d = PH_LEN;
					pos_d   = '0;
				end else begin
					pos_d = pos_inc;
				end
			end
			PH_LEN: begin
				len_d = {len_q[23:0], byte_s1};
				pos_d = pos_inc;
				if (pos_q[1:0] == 2'd3) begin
					phase_d = PH_TYPE;
					pos_d   = '0;
				end
			end
			PH_TYPE: begin
				type_d = {type_q[23:0], byte_s1};
				pos_d  = pos_inc;
				if (pos_q[1:0] == 2'd3) begin
					pos_d = '0;
					fa_d  = '0;
					da_d  = '0;
					if (first_q && type_d != T_IHDR) begin
						phase_d   = PH_HALT;
						res_valid = 1'b1;
						res_kind  = EV_BAD_FIRST;
					end else if (len_q == '0) begin
						finish = 1'b1;
					end else begin
						phase_d = PH_DATA;
					end
				end
			end
			PH_DATA: begin
				// capture the first thirteen data bytes, earliest byte most significant
				if (pos_q < FIELD_BYTES) begin
					fa_d = fa_q | ({56'd0, byte_s1} << {~pos_q[2:0], 3'b000});
				end else if (pos_q < DATA_BYTES) begin
					da_d = da_q | ({32'd0, byte_s1} << {det_sel, 3'b000});
				end
				pos_d = pos_inc;
				if (type_q == T_TEXT && !first_q) begin
					res_valid = 1'b1;
					res_kind  = EV_TEXT;
					res_sv    = byte_s1;
					if (pos_inc == len_q) begin
						phase_d = PH_CRC;
						pos_d   = '0;
					end
				end else if (pos_inc == len_q) begin
					finish = 1'b1;
				end
			end
			PH_CRC: begin
				pos_d = pos_inc;
				if (pos_q[1:0] == 2'd3) begin
					phase_d = PH_LEN;
					pos_d   = '0;
					len_d   = '0;
					type_d  = '0;
				end
			end
			PH_HALT: begin
				phase_d = PH_HALT;
			end
			default: begin
				phase_d = phase_q;
			end
		endcase

		// End of chunk data: report the fields of known chunks
		if (finish) begin
			phase_d = PH_CRC;
			pos_d   = '0;
			case (type_d)
				T_IHDR: begin
					if (first_q) begin
						first_d   = 1'b0;
						res_valid = 1'b1;
						res_kind  = EV_IHDR;
						res_w1    = fa_d[63:32];
						res_w2    = fa_d[31:0];
						res_det   = da_d;
					end
				end
				T_SRGB: begin
					res_valid = 1'b1;
					res_kind  = EV_SRGB;
					res_sv    = fa_d[63:56];
				end
				T_GAMA: begin
					res_valid = 1'b1;
					res_kind  = EV_GAMA;
					res_w1    = fa_d[63:32];
				end
				T_PHYS: begin
					res_valid = 1'b1;
					res_kind  = EV_PHYS;
					res_w1    = fa_d[63:32];
					res_w2    = fa_d[31:0];
					res_sv    = da_d[39:32];
				end
				T_TIME: begin
					res_valid = 1'b1;
					res_kind  = EV_TIME;
					res_w1    = {16'd0, fa_d[63:48]};
					res_det   = fa_d[47:8];
				end
				default: begin
					res_valid = 1'b0;
				end
			endcase
		end
	end

	// Parser state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SIG;
			pos_q   <= '0;
			len_q   <= '0;
			type_q  <= '0;
			first_q <= 1'b1;
		end else if (fire) begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			len_q   <= len_d;
			type_q  <= type_d;
			first_q <= first_d;
		end
	end

	// Data capture, cleared at every fourth type byte before use
	always_ff @(posedge clk) begin
		if (fire) begin
			fa_q <= fa_d;
			da_q <= da_d;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_valid_q <= 1'b0;
		end else if (adv) begin
			ev_valid_q <= fire && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res_valid) begin
			kind_q <= res_kind;
			w1_q   <= res_w1;
			w2_q   <= res_w2;
			det_q  <= res_det;
			sv_q   <= res_sv;
		end
	end

	assign event_valid   = ev_valid_q;
	assign event_kind    = kind_q;
	assign word_one      = w1_q;
	assign word_two      = w2_q;
	assign packed_detail = det_q;
	assign small_value   = sv_q;

	// Halted parser never produces a result
	a_halt_silent: assert property (@(posedge clk) disable iff (!arst_n)
		fire && phase_q == PH_HALT |=> !ev_valid_q)
		else $error("result produced while halted");

	// Error results always leave the parser halted
	a_err_halts: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res_valid && (res_kind == EV_BAD_SIG || res_kind == EV_BAD_FIRST)
		|=> phase_q == PH_HALT)
		else $error("error result without halt");

	// First-chunk flag clears only together with the IHDR result
	a_first_ihdr: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(first_q) |-> ev_valid_q && kind_q == EV_IHDR)
		else $error("first-chunk flag cleared without IHDR result");

	// Text bytes come only after the first chunk is done
	a_text_after_first: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res_valid && res_kind == EV_TEXT |-> !first_q)
		else $error("text byte reported during first chunk");

	// Short phases keep their position counter in range
	a_crc_pos: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_CRC || phase_q == PH_LEN || phase_q == PH_TYPE |-> pos_q < 32'd4)
		else $error("position counter out of range");

endmodule

[tb/sv/tb_png_metadata_chunk_parser.sv]
module tb_png_metadata_chunk_parser;

	import pcp_pkg::*;

	localparam logic [63:0] PNG_SIGNATURE = 64'h8950_4E47_0D0A_1A0A;
	localparam int ITEM_TARGET = 1750;
	localparam int TAIL_BYTES  = 30;
	localparam int HOLD_CYCLES = 300;
	localparam int QUIET_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 10;
	localparam int FILL_RANDOM = 0;
	localparam int FILL_ZERO   = 1;
	localparam int FILL_ONES   = 2;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] w1;
		logic [31:0] w2;
		logic [39:0] det;
		logic [7:0]  sv;
	} png_event_t;

	// Chunk walker mirror plus the queue of events it predicts
	class png_event_board;
		phase_t      phase;
		logic [31:0] pos;
		logic [31:0] clen;
		logic [31:0] ctype;
		logic        first_chunk;
		logic [63:0] field_word;
		logic [39:0] detail_word;
		png_event_t  pending_events[$];
		int          mismatches;

		function new();
			phase       = PH_SIG;
			pos         = '0;
			clen        = '0;
			ctype       = '0;
			first_chunk = 1'b1;
			field_word  = '0;
			detail_word = '0;
			mismatches  = 0;
		endfunction

		function int outstanding();
			return pending_events.size();
		endfunction

		function void post_event(logic [2:0] kind, logic [31:0] w1, logic [31:0] w2,
				logic [39:0] det, logic [7:0] sv);
			png_event_t ev;
			ev.kind = kind;
			ev.w1   = w1;
			ev.w2   = w2;
			ev.det  = det;
			ev.sv   = sv;
			pending_events.push_back(ev);
		endfunction

		// Data complete: go to CRC and report the decoded chunk, if any
		function void close_chunk();
			phase = PH_CRC;
			pos   = '0;
			case (ctype)
				T_IHDR: if (first_chunk) begin
					first_chunk = 1'b0;
					post_event(EV_IHDR, field_word[63:32], field_word[31:0], detail_word, 8'd0);
				end
				T_SRGB: post_event(EV_SRGB, 32'd0, 32'd0, 40'd0, field_word[63:56]);
				T_GAMA: post_event(EV_GAMA, field_word[63:32], 32'd0, 40'd0, 8'd0);
				T_PHYS: post_event(EV_PHYS, field_word[63:32], field_word[31:0], 40'd0,
					detail_word[39:32]);
				T_TIME: post_event(EV_TIME, {16'd0, field_word[63:48]}, 32'd0,
					field_word[47:8], 8'd0);
				default: ;
			endcase
		endfunction

		// One accepted file byte
		function void take_byte(logic [7:0] b);
			case (phase)
				PH_SIG: begin
					if (b != PNG_SIGNATURE[8*(7-pos[2:0]) +: 8]) begin
						phase = PH_HALT;
						post_event(EV_BAD_SIG, 32'd0, 32'd0, 40'd0, 8'd0);
					end else begin
						pos = pos + 1;
						if (pos >= 8) begin
							phase = PH_LEN;
							pos   = '0;
						end
					end
				end
				PH_LEN: begin
					clen = {clen[23:0], b};
					pos  = pos + 1;
					if (pos >= 4) begin
						phase = PH_TYPE;
						pos   = '0;
					end
				end
				PH_TYPE: begin
					ctype = {ctype[23:0], b};
					pos   = pos + 1;
					if (pos >= 4) begin
						pos         = '0;
						field_word  = '0;
						detail_word = '0;
						if (first_chunk && ctype != T_IHDR) begin
							phase = PH_HALT;
							post_event(EV_BAD_FIRST, 32'd0, 32'd0, 40'd0, 8'd0);
						end else if (clen == 0) begin
							close_chunk();
						end else begin
							phase = PH_DATA;
						end
					end
				end
				PH_DATA: begin
					if (pos < 8)
						field_word = field_word | ({56'd0, b} << (8 * (7 - pos)));
					else if (pos < 13)
						detail_word = detail_word | ({32'd0, b} << (8 * (12 - pos)));
					pos = pos + 1;
					if (ctype == T_TEXT && !first_chunk) begin
						if (pos == clen) begin
							phase = PH_CRC;
							pos   = '0;
						end
						post_event(EV_TEXT, 32'd0, 32'd0, 40'd0, b);
					end else if (pos == clen) begin
						close_chunk();
					end
				end
				PH_CRC: begin
					pos = pos + 1;
					if (pos >= 4) begin
						phase = PH_LEN;
						pos   = '0;
						clen  = '0;
						ctype = '0;
					end
				end
				default: ;
			endcase
		endfunction

		// One accepted event against the oldest prediction
		function void check_event(png_event_t got);
			png_event_t want;
			if (pending_events.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected event: kind %0d w1 %h w2 %h det %h sv %h",
						got.kind, got.w1, got.w2, got.det, got.sv);
				return;
			end
			want = pending_events.pop_front();
			if (got.kind !== want.kind || got.w1 !== want.w1 || got.w2 !== want.w2 ||
					got.det !== want.det || got.sv !== want.sv) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("event mismatch: exp kind %0d w1 %h w2 %h det %h sv %h",
						want.kind, want.w1, want.w2, want.det, want.sv);
					$display("                got kind %0d w1 %h w2 %h det %h sv %h",
						got.kind, got.w1, got.w2, got.det, got.sv);
				end
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        byte_valid;
	logic        byte_stall;
	logic [7:0]  stream_byte;
	logic        event_valid;
	logic        event_stall;
	logic [2:0]  event_kind;
	logic [31:0] word_one;
	logic [31:0] word_two;
	logic [39:0] packed_detail;
	logic [7:0]  small_value;

	png_event_board board;
	int bytes_sent;
	int send_idle_pct;
	int stall_pct;
	bit long_hold_req;
	int quiet_cycles;

	png_metadata_chunk_parser DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.byte_valid    (byte_valid),
		.byte_stall    (byte_stall),
		.stream_byte   (stream_byte),
		.event_valid   (event_valid),
		.event_stall   (event_stall),
		.event_kind    (event_kind),
		.word_one      (word_one),
		.word_two      (word_two),
		.packed_detail (packed_detail),
		.small_value   (small_value)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Offer one byte, hold it until the transfer, then predict
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			byte_valid <= 1'b0;
			@(posedge clk);
		end
		byte_valid  <= 1'b1;
		stream_byte <= b;
		@(posedge clk);
		while (byte_stall)
			@(posedge clk);
		board.take_byte(b);
		bytes_sent++;
		// rotate traffic: free flow, sender gaps, receiver stalls, both
		case ((bytes_sent / 250) % 4)
			0: begin send_idle_pct = 0;  stall_pct = 0;  end
			1: begin send_idle_pct = 62; stall_pct = 0;  end
			2: begin send_idle_pct = 0;  stall_pct = 62; end
			default: begin send_idle_pct = 16; stall_pct = 16; end
		endcase
	endtask

	task automatic send_word(input logic [31:0] w);
		for (int i = 3; i >= 0; i--)
			send_byte(w[8*i +: 8]);
	endtask

	task automatic send_signature(input int count);
		for (int i = 0; i < count; i++)
			send_byte(PNG_SIGNATURE[8*(7-i) +: 8]);
	endtask

	// Length, type, data and a random CRC
	task automatic send_chunk(input logic [31:0] ctype, input int len, input int fill);
		logic [7:0] b;
		send_word(len);
		send_word(ctype);
		for (int i = 0; i < len; i++) begin
			b = (fill == FILL_ZERO) ? 8'h00 : (fill == FILL_ONES) ? 8'hFF : 8'($urandom);
			send_byte(b);
		end
		repeat (4) send_byte(8'($urandom));
	endtask

	// Ignored bytes up to the item target
	task automatic send_noise();
		while (bytes_sent < ITEM_TARGET)
			send_byte(8'($urandom));
	endtask

	// Sender stops until every predicted event has come out
	task automatic drain_results();
		byte_valid <= 1'b0;
		do
			@(posedge clk);
		while (board.outstanding() != 0);
	endtask

	// Random chunk with a mostly sensible type and length
	task automatic send_random_chunk();
		logic [31:0] ctype;
		int nominal_len;
		int len;
		int fill;
		case ($urandom_range(0, 15))
			0, 1:     begin ctype = T_IHDR; nominal_len = 13; end
			2, 3:     begin ctype = T_SRGB; nominal_len = 1;  end
			4, 5:     begin ctype = T_GAMA; nominal_len = 4;  end
			6, 7:     begin ctype = T_PHYS; nominal_len = 9;  end
			8, 9:     begin ctype = T_TIME; nominal_len = 7;  end
			10, 11, 12: begin ctype = T_TEXT; nominal_len = $urandom_range(1, 12); end
			13: begin
				// one bit away from a decoded type
				ctype = ($urandom_range(1) ? T_TEXT : T_PHYS) ^ (32'd1 << $urandom_range(0, 31));
				nominal_len = $urandom_range(0, 12);
			end
			default: begin ctype = $urandom; nominal_len = $urandom_range(0, 12); end
		endcase
		case ($urandom_range(0, 9))
			0:       len = 0;
			7, 8:    len = $urandom_range(1, 16);
			9:       len = $urandom_range(17, 40);
			default: len = nominal_len;
		endcase
		case ($urandom_range(0, 7))
			0:       fill = FILL_ZERO;
			1:       fill = FILL_ONES;
			default: fill = FILL_RANDOM;
		endcase
		send_chunk(ctype, len, fill);
	endtask

	// Event side: check transfers, random stalls, one long hold on request
	initial begin
		int hold_left;
		hold_left   = 0;
		event_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && event_valid && !event_stall)
				board.check_event({event_kind, word_one, word_two, packed_detail, small_value});
			if (hold_left > 0) begin
				hold_left--;
				event_stall <= 1'b1;
			end else if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold_left     = HOLD_CYCLES - 1;
				event_stall <= 1'b1;
			end else begin
				event_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	// Watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (byte_valid && !byte_stall) || (event_valid && !event_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("[png_metadata_chunk_parser] ERROR");
			$finish;
		end
	end

	initial begin
		int mode;
		int k;
		logic [7:0] bad;
		logic [31:0] bad_type;
		bit paused;

		board         = new();
		arst_n        = 1'b0;
		byte_valid    = 1'b0;
		stream_byte   = 8'd0;
		bytes_sent    = 0;
		send_idle_pct = 0;
		stall_pct     = 0;
		long_hold_req = 1'b0;
		quiet_cycles  = 0;
		paused        = 1'b0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// a halting error can only come at the start of the file, so a seed picks it rarely
		mode = $urandom_range(0, 9);
		if (mode == 0) begin
			// bad signature at a random position, then ignored bytes
			k = $urandom_range(0, 7);
			send_signature(k);
			bad = 8'($urandom);
			if (bad == PNG_SIGNATURE[8*(7-k) +: 8])
				bad = bad ^ (8'd1 << $urandom_range(0, 7));
			// error result held back while the following bytes back up
			long_hold_req = 1'b1;
			send_byte(bad);
			send_signature(8);
			send_chunk(T_IHDR, 13, FILL_RANDOM);
			drain_results();
			send_noise();
		end else if (mode == 1) begin
			// first chunk not IHDR, then ignored bytes
			send_signature(8);
			case ($urandom_range(0, 2))
				0:       bad_type = T_IHDR ^ (32'd1 << $urandom_range(0, 31));
				1:       bad_type = T_TEXT;
				default: bad_type = $urandom;
			endcase
			if (bad_type == T_IHDR)
				bad_type = T_GAMA;
			send_word($urandom_range(0, 20));
			long_hold_req = 1'b1;
			send_word(bad_type);
			send_chunk(T_IHDR, 13, FILL_RANDOM);
			drain_results();
			send_noise();
		end else begin
			// directed: header, every decoded chunk, short, long, empty and skipped ones
			send_signature(8);
			send_chunk(T_IHDR, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 20) : 13,
				$urandom_range(0, 2));
			send_chunk(T_SRGB, 1, FILL_ONES);
			send_chunk(T_SRGB, 0, FILL_RANDOM);
			send_chunk(T_GAMA, 4, FILL_ONES);
			send_chunk(T_GAMA, 2, FILL_RANDOM);
			send_chunk(T_PHYS, 9, FILL_ONES);
			send_chunk(T_PHYS, 9, FILL_ZERO);
			send_chunk(T_TIME, 7, FILL_ONES);
			send_chunk(T_TIME, 7, FILL_RANDOM);
			send_chunk(T_TEXT, 3, FILL_RANDOM);
			send_chunk(T_TEXT, 0, FILL_RANDOM);
			send_chunk(T_IHDR, 13, FILL_ONES);
			send_chunk(32'h4944_4154, 5, FILL_RANDOM);
			send_chunk(T_SRGB, 20, FILL_ONES);
			// result side holds off while text bytes keep coming
			long_hold_req = 1'b1;
			send_chunk(T_TEXT, 64, FILL_RANDOM);
			drain_results();

			// random chunk stream
			while (bytes_sent < ITEM_TARGET) begin
				if (!paused && bytes_sent > ITEM_TARGET / 2) begin
					drain_results();
					paused = 1'b1;
				end
				send_random_chunk();
			end

			// huge length left unfinished
			send_word($urandom | 32'h8000_0000);
			send_word($urandom_range(1) ? T_TEXT : 32'($urandom));
			repeat (TAIL_BYTES) send_byte(8'($urandom));
		end

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (board.mismatches == 0 && board.outstanding() == 0)
			$display("[png_metadata_chunk_parser] OK");
		else
			$display("[png_metadata_chunk_parser] ERROR");
		$finish;
	end

endmodule
